@@ hdl/vtv_pkg.sv @@
`default_nettype none
package vtv_pkg;

    localparam int COEFF_FRAC_BITS = 12;
    localparam int COORD_FRAC_BITS = 16;

    typedef enum logic [2:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_ROW3   = 3'd3,
        REG_LEFT   = 3'd4,
        REG_TOP    = 3'd5,
        REG_WIDTH  = 3'd6,
        REG_HEIGHT = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic signed [31:0] vertex_w;
    } t_vertex;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] depth_z;
        logic               zero_w;
    } t_screen;

endpackage
`default_nettype wire

@@ hdl/vtv_div_stage.sv @@
`default_nettype none
// One restoring step per stage of a pipelined unsigned divider.
module vtv_div_stage #(
    parameter int QW = 48,
    parameter int DW = 35
) (
    input  wire logic          i_clk,
    input  wire logic [QW-1:0] i_rem_q,
    input  wire logic [DW:0]   i_rem,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_rem_q,
    output logic      [DW:0]   o_rem,
    output logic      [DW-1:0] o_den
);
    logic [DW+1:0] w_try;
    logic [DW+1:0] w_sh;

    always_comb begin
        w_sh  = {i_rem, i_rem_q[QW-1]};
        w_try = w_sh - {2'b00, i_den};
    end

    always_ff @(posedge i_clk) begin
        o_den <= i_den;
        if (!w_try[DW+1]) begin
            o_rem   <= w_try[DW:0];
            o_rem_q <= {i_rem_q[QW-2:0], 1'b1};
        end else begin
            o_rem   <= w_sh[DW:0];
            o_rem_q <= {i_rem_q[QW-2:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

@@ hdl/vertex_transform_viewport.sv @@
// Vertex transform, perspective divide and viewport mapping.
// Pipeline: products, pair sums, clip coords, magnitudes, then one divider stage
// per quotient bit, then ndc saturate, viewport multiply and offset to o_valid.
// Throughput: one vertex per cycle; busy is always low, the divider is
// fully pipelined. The receiver cannot stall; results are strobed for one cycle.
// Reset (synchronous, active low) clears valid bits and restores config.
`default_nettype none
module vertex_transform_viewport #(
    parameter int COEFF_FRAC_BITS = vtv_pkg::COEFF_FRAC_BITS,
    parameter int COORD_FRAC_BITS = vtv_pkg::COORD_FRAC_BITS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire vtv_pkg::t_vertex i_vertex,
    output logic                 o_valid,
    output vtv_pkg::t_screen     o_screen,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [5:0]      paddr,
    input  wire logic [63:0]     pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);
    import vtv_pkg::*;

    localparam int SUMW = 50;
    // magnitude bits of a clip coordinate
    localparam int DW  = SUMW - 1 - COEFF_FRAC_BITS;
    localparam int QW  = DW + COORD_FRAC_BITS;
    localparam int NST = QW;

    // ---------------- configuration ----------------
    logic [63:0] r_row [4];
    logic [11:0] r_left, r_top;
    logic [12:0] r_width, r_height;
    t_reg_idx    w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= 64'h0000_0000_0000_1000;
            r_row[1] <= 64'h0000_0000_1000_0000;
            r_row[2] <= 64'h0000_1000_0000_0000;
            r_row[3] <= 64'h1000_0000_0000_0000;
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= 13'd640;
            r_height <= 13'd480;
        end else if (w_wr && paddr[2:0] == 3'd0) begin
            case (w_idx)
                REG_ROW0:   r_row[0] <= pwdata;
                REG_ROW1:   r_row[1] <= pwdata;
                REG_ROW2:   r_row[2] <= pwdata;
                REG_ROW3:   r_row[3] <= pwdata;
                REG_LEFT:   r_left   <= pwdata[11:0];
                REG_TOP:    r_top    <= pwdata[11:0];
                REG_WIDTH:  r_width  <= pwdata[12:0];
                REG_HEIGHT: r_height <= pwdata[12:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ROW0:   prdata = r_row[0];
            REG_ROW1:   prdata = r_row[1];
            REG_ROW2:   prdata = r_row[2];
            REG_ROW3:   prdata = r_row[3];
            REG_LEFT:   prdata = {52'd0, r_left};
            REG_TOP:    prdata = {52'd0, r_top};
            REG_WIDTH:  prdata = {51'd0, r_width};
            REG_HEIGHT: prdata = {51'd0, r_height};
            default:    prdata = '0;
        endcase
    end

    // ---------------- stage 1: products ----------------
    logic                    r_v1;
    logic signed [47:0]      r_prod [4][4];
    logic signed [31:0]      w_vin  [4];

    assign w_vin[0] = i_vertex.vertex_x;
    assign w_vin[1] = i_vertex.vertex_y;
    assign w_vin[2] = i_vertex.vertex_z;
    assign w_vin[3] = i_vertex.vertex_w;

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                r_prod[r][c] <= $signed(r_row[r][16*c +: 16]) * w_vin[c];
            end
        end
    end

    // ---------------- stage 2: pair sums ----------------
    logic                    r_v2;
    logic signed [48:0]      r_pair [4][2];

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            r_pair[r][0] <= 49'(r_prod[r][0]) + 49'(r_prod[r][1]);
            r_pair[r][1] <= 49'(r_prod[r][2]) + 49'(r_prod[r][3]);
        end
    end

    // ---------------- stage 3: clip coords ----------------
    logic                    r_v3;
    logic signed [SUMW-1:0]  w_sum  [4];
    logic signed [DW:0]      r_clip [4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            w_sum[r] = SUMW'(r_pair[r][0]) + SUMW'(r_pair[r][1]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            r_clip[r] <= (DW+1)'(w_sum[r] >>> COEFF_FRAC_BITS);
        end
    end

    // ---------------- stage 4: magnitudes ----------------
    logic                    r_v4;
    logic [DW-1:0]           r_anum [3];
    logic [DW-1:0]           r_aden;
    logic [2:0]              r_neg4, r_pos4, r_nz4;
    logic                    r_zw4;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_anum[k] <= r_clip[k][DW] ? DW'(-r_clip[k]) : DW'(r_clip[k]);
            r_neg4[k] <= r_clip[k][DW] ^ r_clip[3][DW];
            r_pos4[k] <= !r_clip[k][DW] && (r_clip[k] != '0);
            r_nz4[k]  <= r_clip[k][DW];
        end
        r_aden <= r_clip[3][DW] ? DW'(-r_clip[3]) : DW'(r_clip[3]);
        r_zw4  <= (r_clip[3] == '0);
    end

    // ---------------- divider pipeline ----------------
    logic [QW-1:0] w_q   [3][NST+1];
    logic [DW:0]   w_rem [3][NST+1];
    logic [DW-1:0] w_den [3][NST+1];

    for (genvar k = 0; k < 3; k++) begin : g_div
        assign w_q[k][0]   = {{(QW-DW){1'b0}}, r_anum[k]} << COORD_FRAC_BITS;
        assign w_rem[k][0] = '0;
        assign w_den[k][0] = r_aden;
        for (genvar s = 0; s < NST; s++) begin : g_st
            vtv_div_stage #(.QW(QW), .DW(DW)) u_st (
                .i_clk  (i_clk),
                .i_rem_q(w_q[k][s]),
                .i_rem  (w_rem[k][s]),
                .i_den  (w_den[k][s]),
                .o_rem_q(w_q[k][s+1]),
                .o_rem  (w_rem[k][s+1]),
                .o_den  (w_den[k][s+1])
            );
        end
    end

    // side info travels along the divider
    logic [NST-1:0] r_dv;
    logic [9:0]     r_side [NST];
    logic [11:0]    r_left_p [NST];
    logic [11:0]    r_top_p  [NST];
    logic [12:0]    r_wid_p  [NST];
    logic [12:0]    r_hei_p  [NST];

    always_ff @(posedge i_clk) begin
        r_side[0]   <= {r_zw4, r_neg4, r_pos4, r_nz4};
        r_left_p[0] <= r_left;
        r_top_p[0]  <= r_top;
        r_wid_p[0]  <= r_width;
        r_hei_p[0]  <= r_height;
        for (int s = 1; s < NST; s++) begin
            r_side[s]   <= r_side[s-1];
            r_left_p[s] <= r_left_p[s-1];
            r_top_p[s]  <= r_top_p[s-1];
            r_wid_p[s]  <= r_wid_p[s-1];
            r_hei_p[s]  <= r_hei_p[s-1];
        end
    end

    // ---------------- ndc: sign and saturate ----------------
    logic               r_v5;
    logic signed [31:0] r_ndc [3];
    logic               r_zw5;
    logic [11:0]        r_left5, r_top5;
    logic [12:0]        r_wid5, r_hei5;
    logic [9:0]         w_sd;

    assign w_sd = r_side[NST-1];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (w_sd[9]) begin
                if (w_sd[3+k])      r_ndc[k] <= 32'sh7FFF_FFFF;
                else if (w_sd[k])   r_ndc[k] <= 32'sh8000_0000;
                else                r_ndc[k] <= '0;
            end else if (w_sd[6+k]) begin
                if (w_q[k][NST] > QW'(33'h8000_0000)) r_ndc[k] <= 32'sh8000_0000;
                else r_ndc[k] <= 32'(-w_q[k][NST]);
            end else begin
                if (w_q[k][NST] > QW'(32'h7FFF_FFFF)) r_ndc[k] <= 32'sh7FFF_FFFF;
                else r_ndc[k] <= 32'(w_q[k][NST]);
            end
        end
        r_zw5   <= w_sd[9];
        r_left5 <= r_left_p[NST-1];
        r_top5  <= r_top_p[NST-1];
        r_wid5  <= r_wid_p[NST-1];
        r_hei5  <= r_hei_p[NST-1];
    end

    // ---------------- viewport multiply ----------------
    logic               r_v6;
    logic signed [47:0] r_mx, r_my;
    logic signed [31:0] r_nz6;
    logic               r_zw6;
    logic [11:0]        r_left6, r_top6;

    always_ff @(posedge i_clk) begin
        r_mx    <= (33'(r_ndc[0]) + (33'sd1 <<< COORD_FRAC_BITS))
                   * $signed({1'b0, r_wid5});
        r_my    <= (33'(r_ndc[1]) + (33'sd1 <<< COORD_FRAC_BITS))
                   * $signed({1'b0, r_hei5});
        r_nz6   <= r_ndc[2];
        r_zw6   <= r_zw5;
        r_left6 <= r_left5;
        r_top6  <= r_top5;
    end

    // ---------------- offset and saturate ----------------
    logic signed [48:0] w_sx, w_sy;

    always_comb begin
        w_sx = 49'(r_mx >>> 1) + (49'($signed({1'b0, r_left6})) <<< COORD_FRAC_BITS);
        w_sy = 49'(r_my >>> 1) + (49'($signed({1'b0, r_top6})) <<< COORD_FRAC_BITS);
    end

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        if (v > 49'sh7FFF_FFFF)       sat32 = 32'sh7FFF_FFFF;
        else if (v < -49'sh8000_0000) sat32 = 32'sh8000_0000;
        else                          sat32 = 32'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        o_screen.screen_x <= sat32(w_sx);
        o_screen.screen_y <= sat32(w_sy);
        o_screen.depth_z  <= r_nz6;
        o_screen.zero_w   <= r_zw6;
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_dv <= '0;   r_v5 <= 1'b0; r_v6 <= 1'b0; o_valid <= 1'b0;
        end else begin
            r_v1    <= start && !busy;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_dv    <= {r_dv[NST-2:0], r_v4};
            r_v5    <= r_dv[NST-1];
            r_v6    <= r_v5;
            o_valid <= r_v6;
        end
    end

    // ---------------- assertions ----------------
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> ##(NST+3) o_valid) else $error("lost item in pipeline");
    a_zw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r_zw5 && r_ndc[2] != 0) |=> (r_nz6 == 32'sh7FFF_FFFF || r_nz6 == 32'sh8000_0000))
        else $error("zero w depth not saturated");
    a_nobusy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_v6)) else $error("spurious result");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import vtv_pkg::*;

    localparam int LATENCY = 4 + (49 - COEFF_FRAC_BITS + COORD_FRAC_BITS) + 3;
    localparam int N_RANDOM = 1750;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    t_vertex         i_vertex = '0;
    logic            o_valid;
    t_screen         o_screen;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [5:0]      paddr = '0;
    logic [63:0]     pwdata = '0;
    logic [63:0]     prdata;
    logic            pready;

    vertex_transform_viewport i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_vertex(i_vertex), .o_valid(o_valid), .o_screen(o_screen),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of the configuration
    logic [63:0] mat_row [4];
    logic [11:0] vp_left, vp_top;
    logic [12:0] vp_width, vp_height;

    t_screen pending_screen[$];
    int      n_errors = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic expect_item(input t_screen s);
        pending_screen.insert(pending_screen.size(), s);
    endtask

    function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] div_ndc(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
        logic        neg;
        logic [63:0] a, b, q, r;
        neg = (num < 0) != (den < 0);
        a = num < 0 ? -num : num;
        b = den < 0 ? -den : den;
        if (b == 0) begin
            if (num > 0) return 64'sd2147483647;
            if (num < 0) return -64'sd2147483648;
            return 0;
        end
        q = a / b;
        r = a % b;
        if (q >= 64'h8000_0000) return neg ? -64'sd2147483648 : 64'sd2147483647;
        for (int i = 0; i < COORD_FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
                r = r - b;
                q[0] = 1'b1;
            end
        end
        if (neg) return q > 64'h8000_0000 ? -64'sd2147483648 : -$signed(q);
        return q > 64'h7FFF_FFFF ? 64'sd2147483647 : $signed(q);
    endfunction

    function automatic logic signed [63:0] map_screen(input logic signed [63:0] ndc,
                                                      input logic [12:0] size,
                                                      input logic [11:0] origin);
        logic signed [63:0] one, t;
        one = 64'sd1 <<< COORD_FRAC_BITS;
        t = ((ndc + one) * $signed({51'b0, size})) >>> 1;
        return sat_word(t + $signed({52'b0, origin}) * one);
    endfunction

    function automatic t_screen project_vertex(input t_vertex vx);
        logic signed [63:0] v [4];
        logic signed [63:0] clip [4];
        logic signed [63:0] acc, nx, ny, nz;
        logic signed [15:0] cf;
        t_screen res;
        v[0] = vx.vertex_x; v[1] = vx.vertex_y; v[2] = vx.vertex_z; v[3] = vx.vertex_w;
        for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int c = 0; c < 4; c++) begin
                cf = mat_row[r][16*c +: 16];
                acc += 64'(cf) * v[c];
            end
            clip[r] = acc >>> COEFF_FRAC_BITS;
        end
        nx = div_ndc(clip[0], clip[3]);
        ny = div_ndc(clip[1], clip[3]);
        nz = div_ndc(clip[2], clip[3]);
        res.screen_x = 32'(map_screen(nx, vp_width, vp_left));
        res.screen_y = 32'(map_screen(ny, vp_height, vp_top));
        res.depth_z = 32'(nz);
        res.zero_w = clip[3] == 0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_screen.size() == 0) begin
                report_mismatch("unexpected item", o_screen.screen_x, '0);
            end else begin
                t_screen w;
                w = pending_screen.pop_front();
                if (o_screen.screen_x !== w.screen_x)
                    report_mismatch("screen_x", o_screen.screen_x, w.screen_x);
                if (o_screen.screen_y !== w.screen_y)
                    report_mismatch("screen_y", o_screen.screen_y, w.screen_y);
                if (o_screen.depth_z !== w.depth_z)
                    report_mismatch("depth_z", o_screen.depth_z, w.depth_z);
                if (o_screen.zero_w !== w.zero_w)
                    report_mismatch("zero_w", 32'(o_screen.zero_w), 32'(w.zero_w));
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 6'(idx) << 3; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: mat_row[int'(idx)] = val;
            REG_LEFT:   vp_left = val[11:0];
            REG_TOP:    vp_top = val[11:0];
            REG_WIDTH:  vp_width = val[12:0];
            REG_HEIGHT: vp_height = val[12:0];
            default: ;
        endcase
    endtask

    task automatic drain_items();
        while (pending_screen.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // sender-side burst idling; off near the end
    int idle_left = 0;
    bit idle_on = 1'b1;

    task automatic issue_vertex(input t_vertex vx, input bit checked, input t_screen want);
        if (idle_on && idle_left == 0 && $urandom_range(0, 15) == 0)
            idle_left = $urandom_range(1, 19);
        while (idle_left > 0) begin
            start <= 1'b0;
            @(posedge i_clk);
            idle_left--;
        end
        start <= 1'b1;
        i_vertex <= vx;
        do @(posedge i_clk); while (busy);
        expect_item(checked ? want : project_vertex(vx));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 8) << 16;
            2: return -($urandom_range(0, 8) << 16);
            3: return 32'($signed($urandom_range(0, 200000)) - 100000);
            4: return $urandom & 32'h0003_FFFF;
            default: return 32'sh0001_0000 + $signed($urandom_range(0, 4095)) - 2048;
        endcase
    endfunction

    function automatic logic [15:0] rand_coeff();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'h1000;
            2: return 16'h0000;
            default: return 16'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    typedef struct {
        t_vertex vx;
        bit      checked;
        t_screen want;
    } t_vertex_row;

    t_vertex_row directed_rows [$];

    task automatic add_row(input t_vertex_row rw);
        directed_rows.insert(directed_rows.size(), rw);
    endtask

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_vertex     vx;
        t_screen     ws;
        t_vertex_row row;
        logic [63:0] rowval;

        mat_row[0] = 64'd4096;
        mat_row[1] = 64'd268435456;
        mat_row[2] = 64'd17592186044416;
        mat_row[3] = 64'd1152921504606846976;
        vp_left = 0; vp_top = 0; vp_width = 640; vp_height = 480;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // origin after reset: identity matrix, ndc 0 maps to center
        row.vx = '{0, 0, 0, 32'sh0001_0000}; row.checked = 1;
        row.want = '{32'sd320 <<< 16, 32'sd240 <<< 16, 0, 1'b0};
        add_row(row);
        // zero w, all zero numerators
        row.vx = '{0, 0, 0, 0};
        row.want = '{32'sd320 <<< 16, 32'sd240 <<< 16, 0, 1'b1};
        add_row(row);
        // zero w, positive and negative numerators saturate
        row.vx = '{32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 0};
        row.want = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1};
        add_row(row);
        row.checked = 0;
        row.vx = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        add_row(row);
        row.vx = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        add_row(row);
        row.vx = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001};
        add_row(row);
        row.vx = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        add_row(row);
        row.vx = '{32'sh0000_8000, -32'sh0000_8000, 32'sh0000_4000, 32'sh0002_0000};
        add_row(row);
        row.vx = '{-32'sh0003_0000, 32'sh0005_0000, -32'sh0000_0001, -32'sh0001_0000};
        add_row(row);
        row.vx = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000};
        add_row(row);

        foreach (directed_rows[k])
            issue_vertex(directed_rows[k].vx, directed_rows[k].checked, directed_rows[k].want);
        start <= 1'b0;
        drain_items();

        // extreme viewport, full-range matrix
        write_reg(REG_LEFT, 64'hFFF);
        write_reg(REG_TOP, 64'hFFF);
        write_reg(REG_WIDTH, 64'd4096);
        write_reg(REG_HEIGHT, 64'h1FFF);
        write_reg(REG_ROW0, 64'h7FFF_8000_7FFF_8000);
        write_reg(REG_ROW1, 64'h8000_7FFF_8000_7FFF);
        write_reg(REG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_ROW3, 64'h0000_0000_0000_0000);
        for (int k = 0; k < 6; k++) begin
            vx = '{rand_coord(), rand_coord(), rand_coord(), rand_coord()};
            issue_vertex(vx, 0, ws);
        end
        start <= 1'b0;
        drain_items();

        for (int phase = 0; phase < 6; phase++) begin
            write_reg(REG_LEFT, phase == 1 ? 64'd0 : 64'($urandom_range(0, 4095)));
            write_reg(REG_TOP, 64'($urandom_range(0, 4095)));
            write_reg(REG_WIDTH, phase == 1 ? 64'd0 : 64'($urandom_range(0, 4096)));
            write_reg(REG_HEIGHT, 64'($urandom_range(0, 4096)));
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++)
                    rowval[16*c +: 16] = (phase % 2 == 0)
                        ? ((r == c) ? 16'h1000 + 16'($urandom_range(0, 511)) : 16'h0000)
                        : rand_coeff();
                write_reg(t_reg_idx'(r), rowval);
            end
            if (phase == 5) idle_on = 1'b0;
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                vx = '{rand_coord(), rand_coord(), rand_coord(), rand_coord()};
                if ($urandom_range(0, 31) == 0) vx.vertex_w = 0;
                issue_vertex(vx, 0, ws);
                if (phase == 2 && k == 100) begin
                    start <= 1'b0;
                    while (pending_screen.size() != 0) @(posedge i_clk);
                end
            end
            start <= 1'b0;
            drain_items();
        end

        if (n_errors == 0 && pending_screen.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
